### design/lpb_pkg.sv
// ----------------------------------------------------------------------------
// lpb_pkg: shared types and constants for the load proportional LED blinker
// Widths, register indexes, reset values and the divider request/response
// structs used between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package lpb_pkg;

	localparam int CHANNELS   = 4;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TICK_W     = 32;
	localparam int USAGE_W    = 7;
	localparam int THR_W      = 7;
	localparam int BASE_W     = 12;
	localparam int PROD_W     = USAGE_W + BASE_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam int DIV_STEPS  = TICK_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_INTERVAL = 1'b1;

	localparam logic [THR_W-1:0]  THR_RESET    = 7'd91;
	localparam logic [BASE_W-1:0] BASE_RESET   = 12'd184;
	localparam logic [BASE_W-1:0] MIN_INTERVAL = 12'd2;

	typedef struct packed {
		logic              start;
		logic [TICK_W-1:0] dividend;
		logic [BASE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [TICK_W-1:0] quotient;
		logic [BASE_W-1:0] remainder;
	} div_rsp_t;

endpackage

### design/lpb_div.sv
// ----------------------------------------------------------------------------
// lpb_div: shared restoring divider
// One quotient bit per cycle over a 32-bit dividend and a 12-bit nonzero
// divisor. Quotient and remainder are valid while done is high.
// ----------------------------------------------------------------------------
module lpb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lpb_pkg::div_req_t req,
	output lpb_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [lpb_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [lpb_pkg::TICK_W-1:0]     quo_q;
	logic [lpb_pkg::BASE_W-1:0]     rem_q;
	logic [lpb_pkg::BASE_W-1:0]     divisor_q;

	logic [lpb_pkg::BASE_W:0]       trial;
	logic [lpb_pkg::BASE_W+1:0]     diff;
	logic                           fits;

	// bring down the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[lpb_pkg::TICK_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, divisor_q};
	assign fits  = ~diff[lpb_pkg::BASE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lpb_pkg::DIV_CNT_W'(lpb_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[lpb_pkg::TICK_W-2:0], fits};
			rem_q <= fits ? diff[lpb_pkg::BASE_W-1:0] : trial[lpb_pkg::BASE_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

### design/load_proportional_led_blinker.sv
// ----------------------------------------------------------------------------
// load_proportional_led_blinker: per-tick LED levels from channel load
// Each tick visits every channel in turn: a steady channel passes through the
// check and advance states, a blinking one also runs two divider passes.
// A new tick waits until the result is loaded; a held result stalls the next.
// Reset: tick counter 0, stored LED levels off, threshold 91, base interval 184.
// ----------------------------------------------------------------------------
module load_proportional_led_blinker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lpb_pkg::USAGE_W-1:0]      usage_0,
	input  logic [lpb_pkg::USAGE_W-1:0]      usage_1,
	input  logic [lpb_pkg::USAGE_W-1:0]      usage_2,
	input  logic [lpb_pkg::USAGE_W-1:0]      usage_3,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lpb_pkg::CHANNELS-1:0]     led_levels_out,
	output logic [lpb_pkg::CHANNELS-1:0]     change_mask,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lpb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_ADV  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]                         state_q;
	logic [lpb_pkg::CH_W-1:0]           ch_q;
	logic [lpb_pkg::USAGE_W-1:0]        usage_q [lpb_pkg::CHANNELS];
	logic [lpb_pkg::TICK_W-1:0]         tick_q;
	logic [lpb_pkg::CHANNELS-1:0]       led_q;
	logic [lpb_pkg::CHANNELS-1:0]       next_q;
	logic [lpb_pkg::BASE_W-1:0]         interval_q;
	logic [lpb_pkg::THR_W-1:0]          thr_q;
	logic [lpb_pkg::BASE_W-1:0]         base_q;
	logic                               out_valid_q;
	logic [lpb_pkg::CHANNELS-1:0]       levels_q;
	logic [lpb_pkg::CHANNELS-1:0]       mask_q;

	logic [lpb_pkg::USAGE_W-1:0]        load_cur;
	logic [lpb_pkg::PROD_W-1:0]         prod;
	logic [lpb_pkg::BASE_W-1:0]         interval_raw;
	logic                               out_load;
	lpb_pkg::div_req_t                  div_req;
	lpb_pkg::div_rsp_t                  div_rsp;

	lpb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign load_cur     = usage_q[ch_q];
	assign prod         = lpb_pkg::PROD_W'(load_cur) * lpb_pkg::PROD_W'(base_q);
	assign interval_raw = base_q - div_rsp.quotient[lpb_pkg::BASE_W-1:0];
	assign out_load     = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		if (state_q == ST_CHK) begin
			// scaled load: load*base/threshold
			div_req.start    = (load_cur != '0) && (load_cur <= thr_q);
			div_req.dividend = lpb_pkg::TICK_W'(prod);
			div_req.divisor  = lpb_pkg::BASE_W'(thr_q);
		end else if (state_q == ST_MOD) begin
			div_req.start    = 1'b1;
			div_req.dividend = tick_q;
			div_req.divisor  = interval_q;
		end
	end

	assign in_ready       = (state_q == ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign led_levels_out = levels_q;
	assign change_mask    = mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			tick_q      <= '0;
			led_q       <= '0;
			thr_q       <= lpb_pkg::THR_RESET;
			base_q      <= lpb_pkg::BASE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lpb_pkg::REG_THRESHOLD:     thr_q  <= cfg_data[lpb_pkg::THR_W-1:0];
					lpb_pkg::REG_BASE_INTERVAL: base_q <= cfg_data[lpb_pkg::BASE_W-1:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						tick_q  <= tick_q + 1'b1;
						ch_q    <= '0;
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= div_req.start ? ST_DIV1 : ST_ADV;
				end
				ST_DIV1: begin
					if (div_rsp.done) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_rsp.done) begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (ch_q == lpb_pkg::CH_W'(lpb_pkg::CHANNELS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						led_q   <= next_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			usage_q[0] <= usage_0;
			usage_q[1] <= usage_1;
			usage_q[2] <= usage_2;
			usage_q[3] <= usage_3;
		end
		if (state_q == ST_CHK) begin
			// off at zero load, steady on above threshold
			next_q[ch_q] <= (load_cur != '0) && (load_cur > thr_q);
		end
		if (state_q == ST_DIV1 && div_rsp.done) begin
			interval_q <= (interval_raw < lpb_pkg::MIN_INTERVAL) ?
				lpb_pkg::MIN_INTERVAL : interval_raw;
		end
		if (state_q == ST_DIV2 && div_rsp.done) begin
			next_q[ch_q] <= (div_rsp.remainder == '0);
		end
		if (out_load) begin
			levels_q <= next_q;
			mask_q   <= next_q ^ led_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_rsp.busy)
		else $error("divider busy while taking a new word");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished outside a wait state");

	a_interval_floor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MOD |-> interval_q >= lpb_pkg::MIN_INTERVAL)
		else $error("blink interval below floor");

	a_levels_track: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> led_q == led_levels_out)
		else $error("stored levels differ from presented word");
`endif

endmodule
